### rtl/txss_pkg.sv
// Shared types, byte codes and enums for the telnet/markup stream splitter.
// No dependencies; every other rtl file imports this package.
package txss_pkg;

    localparam int BURST_MAX = 5;

    typedef struct packed {
        logic [7:0] data;
        logic       end_of_chunk;
    } in_word_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        logic       ends_segment;
        logic [1:0] segment_kind;
        logic       last;
    } out_word_t;

    // one result without its last flag, as it sits in the queue
    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        logic       ends_segment;
        logic [1:0] segment_kind;
    } res_t;

    // all results caused by one input byte
    typedef struct packed {
        logic [2:0]                 count;
        res_t [BURST_MAX-1:0]       res;
    } burst_t;

    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_TAG  = 2'd1,
        MODE_ENT  = 2'd2,
        MODE_TEL  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ENT_NONE = 3'd0,
        ENT_AMP  = 3'd1,
        ENT_L    = 3'd2,
        ENT_G    = 3'd3,
        ENT_A    = 3'd4,
        ENT_AM   = 3'd5,
        ENT_LAST = 3'd6
    } ent_step_t;

    typedef enum logic [2:0] {
        TEL_NONE  = 3'd0,
        TEL_IAC   = 3'd1,
        TEL_SKIP  = 3'd2,
        TEL_SB    = 3'd3,
        TEL_SBIAC = 3'd4
    } tel_step_t;

    localparam logic [1:0] KIND_LINE = 2'd0;
    localparam logic [1:0] KIND_FRAG = 2'd1;
    localparam logic [1:0] KIND_TEL  = 2'd2;

    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_LT   = 8'h3c;
    localparam logic [7:0] CH_GT   = 8'h3e;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [7:0] CH_L    = 8'h6c;
    localparam logic [7:0] CH_G    = 8'h67;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_M    = 8'h6d;
    localparam logic [7:0] CH_P    = 8'h70;

    localparam logic [7:0] TN_IAC  = 8'hff;
    localparam logic [7:0] TN_SB   = 8'hfa;
    localparam logic [7:0] TN_WILL = 8'hfb;
    localparam logic [7:0] TN_DONT = 8'hfe;

    function automatic res_t mk_res(input logic has, input logic [7:0] b,
                                    input logic ends, input logic [1:0] kind);
        res_t r;
        r.has_byte     = has;
        r.out_byte     = b;
        r.ends_segment = ends;
        r.segment_kind = kind;
        return r;
    endfunction

endpackage

### rtl/txss_front.sv
// Front end: parses one byte per cycle unless the queue is full, and builds the burst
// of results it causes. Holds parser state and the markup-mode register. Depends on txss_pkg.
module txss_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  txss_pkg::in_word_t in_data,
    input  logic              cfg_valid,
    input  logic              cfg_data,
    input  logic              q_full,
    output logic              q_push,
    output txss_pkg::burst_t  q_data
);
    import txss_pkg::*;

    logic      xml_mode_reg;
    mode_t     mode_reg, mode_next;
    ent_step_t ent_reg, ent_next;
    tel_step_t tel_reg, tel_next;
    logic [7:0] held_reg [4];
    logic [7:0] held_next [4];
    logic [2:0] held_cnt_reg, held_cnt_next;
    logic       seg_open_reg, seg_open_next;

    logic       accept;
    logic [7:0] b;
    res_t [BURST_MAX-1:0] r;
    logic [2:0] n;
    logic       is_gt, is_lt, is_amp;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign b        = in_data.data;

    assign is_gt  = held_cnt_reg == 3'd3 && held_reg[0] == CH_AMP && held_reg[1] == CH_G
                    && held_reg[2] == CH_T;
    assign is_lt  = held_cnt_reg == 3'd3 && held_reg[0] == CH_AMP && held_reg[1] == CH_L
                    && held_reg[2] == CH_T;
    assign is_amp = held_cnt_reg == 3'd4 && held_reg[0] == CH_AMP && held_reg[1] == CH_A
                    && held_reg[2] == CH_M && held_reg[3] == CH_P;

    always_comb
    begin
        logic fail;
        logic take;
        logic tel_done;
        mode_next     = mode_reg;
        ent_next      = ent_reg;
        tel_next      = tel_reg;
        held_next     = held_reg;
        held_cnt_next = held_cnt_reg;
        seg_open_next = seg_open_reg;
        r             = '0;
        n             = 3'd0;
        fail          = 1'b0;
        take          = 1'b0;
        tel_done      = 1'b0;

        unique case (mode_reg)
            MODE_TEXT:
            begin
                if (b == TN_IAC)
                begin
                    if (seg_open_reg)
                    begin
                        r[n] = mk_res(1'b0, 8'd0, 1'b1, KIND_FRAG);
                        n = n + 3'd1;
                    end
                    r[n] = mk_res(1'b1, b, 1'b0, KIND_TEL);
                    n = n + 3'd1;
                    seg_open_next = 1'b1;
                    mode_next     = MODE_TEL;
                    tel_next      = TEL_IAC;
                end
                else if (b == CH_LF)
                begin
                    r[0] = mk_res(1'b1, b, 1'b1, KIND_LINE);
                    n = 3'd1;
                    seg_open_next = 1'b0;
                end
                else if (b == CH_LT && xml_mode_reg)
                begin
                    if (seg_open_reg)
                    begin
                        r[0] = mk_res(1'b0, 8'd0, 1'b1, KIND_FRAG);
                        n = 3'd1;
                    end
                    seg_open_next = 1'b0;
                    held_cnt_next = 3'd0;
                    mode_next     = MODE_TAG;
                end
                else if (b == CH_AMP && xml_mode_reg)
                begin
                    held_next[0]  = b;
                    held_cnt_next = 3'd1;
                    ent_next      = ENT_AMP;
                    mode_next     = MODE_ENT;
                end
                else
                begin
                    r[0] = mk_res(1'b1, b, 1'b0, KIND_FRAG);
                    n = 3'd1;
                    seg_open_next = 1'b1;
                end
            end
            MODE_TAG:
            begin
                if (b == CH_GT)
                begin
                    mode_next     = MODE_TEXT;
                    ent_next      = ENT_NONE;
                    held_cnt_next = 3'd0;
                end
            end
            MODE_ENT:
            begin
                unique case (ent_reg)
                    ENT_AMP:
                    begin
                        if (b == CH_L)      begin take = 1'b1; ent_next = ENT_L; end
                        else if (b == CH_G) begin take = 1'b1; ent_next = ENT_G; end
                        else if (b == CH_A) begin take = 1'b1; ent_next = ENT_A; end
                        else fail = 1'b1;
                    end
                    ENT_L, ENT_G:
                    begin
                        if (b == CH_T) begin take = 1'b1; ent_next = ENT_LAST; end
                        else fail = 1'b1;
                    end
                    ENT_A:
                    begin
                        if (b == CH_M) begin take = 1'b1; ent_next = ENT_AM; end
                        else fail = 1'b1;
                    end
                    ENT_AM:
                    begin
                        if (b == CH_P) begin take = 1'b1; ent_next = ENT_LAST; end
                        else fail = 1'b1;
                    end
                    ENT_LAST:
                    begin
                        if (b == CH_SEMI)
                        begin
                            if (is_gt || is_lt || is_amp)
                            begin
                                r[0] = mk_res(1'b1, is_gt ? CH_GT : (is_lt ? CH_LT : CH_AMP),
                                              1'b0, KIND_FRAG);
                                n = 3'd1;
                                seg_open_next = 1'b1;
                            end
                            mode_next     = MODE_TEXT;
                            ent_next      = ENT_NONE;
                            held_cnt_next = 3'd0;
                        end
                        else fail = 1'b1;
                    end
                    default: fail = 1'b1;
                endcase

                // held chars are appended only while there is room
                if (take && held_cnt_reg < 3'd4)
                begin
                    held_next[held_cnt_reg[1:0]] = b;
                    held_cnt_next = held_cnt_reg + 3'd1;
                end

                // failed entity: replay held chars, then the raw byte
                if (fail)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        if (3'(i) < held_cnt_reg)
                            r[i] = mk_res(1'b1, held_reg[i], 1'b0, KIND_FRAG);
                    end
                    r[held_cnt_reg] = mk_res(1'b1, b, 1'b0, KIND_FRAG);
                    n = held_cnt_reg + 3'd1;
                    seg_open_next = 1'b1;
                    mode_next     = MODE_TEXT;
                    ent_next      = ENT_NONE;
                    held_cnt_next = 3'd0;
                end
            end
            MODE_TEL:
            begin
                unique case (tel_reg)
                    TEL_IAC:
                    begin
                        if (b >= TN_WILL && b <= TN_DONT) tel_next = TEL_SKIP;
                        else if (b == TN_SB)              tel_next = TEL_SB;
                        else                              tel_done = 1'b1;
                    end
                    TEL_SB:
                    begin
                        if (b == TN_IAC) tel_next = TEL_SBIAC;
                    end
                    TEL_SBIAC:
                    begin
                        if (b == TN_IAC) tel_next = TEL_SB;
                        else             tel_done = 1'b1;
                    end
                    default: tel_done = 1'b1;
                endcase
                r[0] = mk_res(1'b1, b, tel_done, KIND_TEL);
                n = 3'd1;
                if (tel_done)
                begin
                    seg_open_next = 1'b0;
                    tel_next      = TEL_NONE;
                    mode_next     = MODE_TEXT;
                end
            end
            default: ;
        endcase

        // chunk end closes the open segment
        if (in_data.end_of_chunk)
        begin
            held_cnt_next = 3'd0;
            if (seg_open_next)
            begin
                if (n != 3'd0 && r[n - 3'd1].has_byte && !r[n - 3'd1].ends_segment)
                    r[n - 3'd1].ends_segment = 1'b1;
                else if (n < 3'(BURST_MAX))
                begin
                    r[n] = mk_res(1'b0, 8'd0, 1'b1,
                                  (mode_next == MODE_TEL) ? KIND_TEL : KIND_FRAG);
                    n = n + 3'd1;
                end
                seg_open_next = 1'b0;
            end
        end
    end

    assign q_push       = accept && (n != 3'd0);
    assign q_data.count = n;
    assign q_data.res   = r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xml_mode_reg <= 1'b0;
            mode_reg     <= MODE_TEXT;
            ent_reg      <= ENT_NONE;
            tel_reg      <= TEL_NONE;
            held_cnt_reg <= 3'd0;
            seg_open_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                xml_mode_reg <= cfg_data;
            if (accept)
            begin
                mode_reg     <= mode_next;
                ent_reg      <= ent_next;
                tel_reg      <= tel_next;
                held_cnt_reg <= held_cnt_next;
                seg_open_reg <= seg_open_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            held_reg <= held_next;
    end

endmodule

### rtl/txss_fifo.sv
// Two-entry queue of result bursts between the parser and the output sequencer.
// Depends on txss_pkg.
module txss_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  txss_pkg::burst_t push_data,
    input  logic             pop,
    output txss_pkg::burst_t head,
    output logic             full,
    output logic             empty
);
    import txss_pkg::*;

    burst_t     mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            unique case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

### rtl/txss_back.sv
// Output sequencer: sends the results of the head burst one word per cycle while out_ready is high.
// Depends on txss_pkg.
module txss_back (
    input  logic              clk,
    input  logic              rst_n,
    input  txss_pkg::burst_t  head,
    input  logic              empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output txss_pkg::out_word_t out_data
);
    import txss_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic       is_last;
    res_t       cur;

    assign cur       = head.res[idx_reg];
    assign is_last   = idx_reg == head.count - 3'd1;
    assign out_valid = !empty;
    assign pop       = out_valid && out_ready && is_last;

    assign out_data.has_byte     = cur.has_byte;
    assign out_data.out_byte     = cur.out_byte;
    assign out_data.ends_segment = cur.ends_segment;
    assign out_data.segment_kind = cur.segment_kind;
    assign out_data.last         = is_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (out_valid && out_ready)
            idx_next = is_last ? 3'd0 : idx_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 3'd0;
        else
            idx_reg <= idx_next;
    end

endmodule

### rtl/telnet_xml_stream_splitter.sv
// The burst a byte causes is registered in the queue before its first result is offered.
// Throughput: one input byte per cycle while the queue is not full; the output sends one
// word per cycle while out_ready is high, so a byte causing k results (k up to 5) holds
// the output for k words, buffered by a two-burst queue. Bytes causing no result push nothing.
// Reset: rst_n clears parser state, markup mode, queue and sequencer at once.
// Depends on txss_pkg, txss_front, txss_fifo, txss_back.
module telnet_xml_stream_splitter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  txss_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output txss_pkg::out_word_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);
    import txss_pkg::*;

    logic   q_full, q_empty, q_push, q_pop;
    burst_t q_in, q_head;

    assign cfg_ready = 1'b1;

    txss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    txss_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    txss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### sim/txss_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the telnet/markup stream splitter: tracks parser state, predicts
// the output words of every accepted byte and compares them in order. Uses txss_pkg.
module txss_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  txss_pkg::in_word_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  txss_pkg::out_word_t out_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic                cfg_data,
    output int                  errors,
    output int                  pending,
    output int                  words_checked
);
    import txss_pkg::*;

    logic       xml_on;
    mode_t      mode;
    ent_step_t  ent;
    tel_step_t  tel;
    logic [7:0] held [4];
    int         held_n;
    logic       seg_open;

    out_word_t  step_words [$];
    out_word_t  want_words [$];

    function automatic void add_word(input logic has, input logic [7:0] b,
                                     input logic ends, input logic [1:0] kind);
        out_word_t w;
        if (step_words.size() >= BURST_MAX)
            return;
        w.has_byte     = has;
        w.out_byte     = b;
        w.ends_segment = ends;
        w.segment_kind = kind;
        w.last         = 1'b0;
        step_words.push_back(w);
    endfunction

    function automatic void hold_char(input logic [7:0] b);
        if (held_n < 4)
        begin
            held[held_n] = b;
            held_n++;
        end
    endfunction

    function automatic void to_text();
        mode   = MODE_TEXT;
        ent    = ENT_NONE;
        held_n = 0;
    endfunction

    // broken entity: replay what was held, then the byte itself, uninterpreted
    function automatic void flush_entity(input logic [7:0] b);
        for (int i = 0; i < held_n; i++)
            add_word(1'b1, held[i], 1'b0, KIND_FRAG);
        add_word(1'b1, b, 1'b0, KIND_FRAG);
        seg_open = 1'b1;
        to_text();
    endfunction

    function automatic void entity_want(input logic [7:0] b, input logic [7:0] c,
                                        input ent_step_t nxt);
        if (b == c)
        begin
            hold_char(b);
            ent = nxt;
        end
        else
            flush_entity(b);
    endfunction

    function automatic bit held_matches(input int n, input logic [7:0] c0,
                                        input logic [7:0] c1, input logic [7:0] c2,
                                        input logic [7:0] c3);
        if (held_n != n)
            return 1'b0;
        return held[0] == c0 && held[1] == c1 && held[2] == c2 && (n < 4 || held[3] == c3);
    endfunction

    task automatic split_byte(input in_word_t w);
        logic [7:0] b;
        logic [7:0] decoded;
        logic       done;
        int         top;
        b = w.data;
        step_words.delete();
        case (mode)
            MODE_TEXT:
            begin
                if (b == TN_IAC)
                begin
                    if (seg_open)
                        add_word(1'b0, 8'h00, 1'b1, KIND_FRAG);
                    add_word(1'b1, b, 1'b0, KIND_TEL);
                    seg_open = 1'b1;
                    mode     = MODE_TEL;
                    tel      = TEL_IAC;
                end
                else if (b == CH_LF)
                begin
                    add_word(1'b1, b, 1'b1, KIND_LINE);
                    seg_open = 1'b0;
                end
                else if (b == CH_LT && xml_on)
                begin
                    if (seg_open)
                        add_word(1'b0, 8'h00, 1'b1, KIND_FRAG);
                    seg_open = 1'b0;
                    held_n   = 0;
                    mode     = MODE_TAG;
                end
                else if (b == CH_AMP && xml_on)
                begin
                    held_n = 0;
                    hold_char(b);
                    ent  = ENT_AMP;
                    mode = MODE_ENT;
                end
                else
                begin
                    add_word(1'b1, b, 1'b0, KIND_FRAG);
                    seg_open = 1'b1;
                end
            end
            MODE_TAG:
            begin
                if (b == CH_GT)
                    to_text();
            end
            MODE_ENT:
            begin
                case (ent)
                    ENT_AMP:
                    begin
                        if (b == CH_L)
                        begin
                            hold_char(b);
                            ent = ENT_L;
                        end
                        else if (b == CH_G)
                        begin
                            hold_char(b);
                            ent = ENT_G;
                        end
                        else if (b == CH_A)
                        begin
                            hold_char(b);
                            ent = ENT_A;
                        end
                        else
                            flush_entity(b);
                    end
                    ENT_L, ENT_G: entity_want(b, CH_T, ENT_LAST);
                    ENT_A:        entity_want(b, CH_M, ENT_AM);
                    ENT_AM:       entity_want(b, CH_P, ENT_LAST);
                    ENT_LAST:
                    begin
                        if (b == CH_SEMI)
                        begin
                            // held chars may have been dropped by a chunk end
                            decoded = 8'h00;
                            if (held_matches(3, CH_AMP, CH_G, CH_T, 8'h00))
                                decoded = CH_GT;
                            else if (held_matches(3, CH_AMP, CH_L, CH_T, 8'h00))
                                decoded = CH_LT;
                            else if (held_matches(4, CH_AMP, CH_A, CH_M, CH_P))
                                decoded = CH_AMP;
                            if (decoded != 8'h00)
                            begin
                                add_word(1'b1, decoded, 1'b0, KIND_FRAG);
                                seg_open = 1'b1;
                            end
                            to_text();
                        end
                        else
                            flush_entity(b);
                    end
                    default: flush_entity(b);
                endcase
            end
            default:
            begin
                done = 1'b0;
                case (tel)
                    TEL_IAC:
                    begin
                        if (b >= TN_WILL && b <= TN_DONT)
                            tel = TEL_SKIP;
                        else if (b == TN_SB)
                            tel = TEL_SB;
                        else
                            done = 1'b1;
                    end
                    TEL_SB:
                    begin
                        if (b == TN_IAC)
                            tel = TEL_SBIAC;
                    end
                    TEL_SBIAC:
                    begin
                        if (b == TN_IAC)
                            tel = TEL_SB;
                        else
                            done = 1'b1;
                    end
                    default: done = 1'b1;
                endcase
                add_word(1'b1, b, done, KIND_TEL);
                if (done)
                begin
                    seg_open = 1'b0;
                    tel      = TEL_NONE;
                    mode     = MODE_TEXT;
                end
            end
        endcase

        if (w.end_of_chunk)
        begin
            held_n = 0;
            if (seg_open)
            begin
                top = step_words.size() - 1;
                if (top >= 0 && step_words[top].has_byte && !step_words[top].ends_segment)
                    step_words[top].ends_segment = 1'b1;
                else
                    add_word(1'b0, 8'h00, 1'b1, (mode == MODE_TEL) ? KIND_TEL : KIND_FRAG);
                seg_open = 1'b0;
            end
        end

        if (step_words.size() > 0)
            step_words[step_words.size() - 1].last = 1'b1;
        foreach (step_words[i])
            want_words.push_back(step_words[i]);
    endtask

    task automatic note_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
        errors++;
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            xml_on        = 1'b0;
            mode          = MODE_TEXT;
            ent           = ENT_NONE;
            tel           = TEL_NONE;
            held_n        = 0;
            seg_open      = 1'b0;
            want_words.delete();
            errors        = 0;
            pending       = 0;
            words_checked = 0;
        end
        else
        begin
            // compare before predicting: a word never leaves in the cycle its byte enters
            if (out_valid && out_ready)
            begin
                words_checked++;
                if (want_words.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected word, expected none, got %h", $time, out_data);
                end
                else
                begin
                    want = want_words.pop_front();
                    if (out_data.has_byte !== want.has_byte)
                        note_mismatch("has_byte", want.has_byte, out_data.has_byte);
                    if (out_data.out_byte !== want.out_byte)
                        note_mismatch("out_byte", want.out_byte, out_data.out_byte);
                    if (out_data.ends_segment !== want.ends_segment)
                        note_mismatch("ends_segment", want.ends_segment, out_data.ends_segment);
                    if (out_data.segment_kind !== want.segment_kind)
                        note_mismatch("segment_kind", want.segment_kind, out_data.segment_kind);
                    if (out_data.last !== want.last)
                        note_mismatch("last", want.last, out_data.last);
                end
            end
            if (cfg_valid && cfg_ready)
                xml_on = cfg_data;
            if (in_valid && in_ready)
                split_byte(in_data);
            pending = want_words.size();
        end
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Top of the splitter testbench: clock, reset, byte stimulus, markup mode writes,
// output stalls and the verdict. Uses txss_pkg and the txss_checker scoreboard.
module testbench;
    import txss_pkg::*;

    localparam int         IDLE_LIMIT = 2000;
    localparam int         PHASE_ITEMS = 34;
    localparam logic [7:0] TN_SE = 8'hf0;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_word_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data = 1'b0;

    int errors;
    int pending;
    int words_checked;

    int burst_left = 0;
    int bytes_sent = 0;
    int directed_bytes = 0;
    int mode_writes = 0;
    int phase_items = 0;
    int idle_cycles = 0;
    int rx_count = 0;
    int rx_style = 0;

    telnet_xml_stream_splitter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    txss_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending),
        .words_checked (words_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls: out_ready follows one of four styles, redrawn at random
    always @(posedge clk)
    begin
        rx_count++;
        if (rx_count % 64 == 0)
            rx_style = $urandom_range(0, 3);
        case (rx_style)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (rx_count % 7 != 3) && (rx_count % 7 != 4);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // sender: bursts of random length with random gaps between them
    task automatic send_byte(input logic [7:0] b, input logic eoc);
        int       gap;
        in_word_t w;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        w.data = b;
        w.end_of_chunk = eoc;
        in_valid <= 1'b1;
        in_data <= w;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_str(input string s, input logic eoc_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eoc_last && (i == s.len() - 1));
    endtask

    // wait until every predicted word is out, then wait on so that a byte with no word also settles
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(input logic v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mode_writes++;
    endtask

    // one well-formed or broken token with random content
    task automatic send_token(input logic xml);
        logic [7:0] seq [$];
        string      ent;
        int         style;
        int         n;
        style = $urandom_range(0, 15);
        if (style <= 4)
        begin
            n = $urandom_range(1, 4);
            repeat (n) seq.push_back(8'($urandom_range(8'h20, 8'h7e)));
        end
        else if (style <= 6)
            seq.push_back(CH_LF);
        else if (style <= 9)
        begin
            case ($urandom_range(0, 2))
                0: ent = "&lt;";
                1: ent = "&gt;";
                default: ent = "&amp;";
            endcase
            n = (style == 9) ? $urandom_range(1, ent.len() - 1) : ent.len();
            for (int i = 0; i < n; i++)
                seq.push_back(ent[i]);
            if (style == 9)
                seq.push_back(8'($urandom_range(0, 255)));
        end
        else if (style <= 11)
        begin
            seq.push_back(CH_LT);
            repeat ($urandom_range(0, 3)) seq.push_back(8'($urandom_range(8'h20, 8'h7e)));
            seq.push_back(CH_GT);
        end
        else if (style <= 13)
        begin
            seq.push_back(TN_IAC);
            case ($urandom_range(0, 2))
                0:
                begin
                    seq.push_back(8'($urandom_range(TN_WILL, TN_DONT)));
                    seq.push_back(8'($urandom_range(0, 255)));
                end
                1:
                begin
                    seq.push_back(TN_SB);
                    repeat ($urandom_range(0, 3))
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            seq.push_back(TN_IAC);
                            seq.push_back(TN_IAC);
                        end
                        else
                            seq.push_back(8'($urandom_range(0, 254)));
                    end
                    seq.push_back(TN_IAC);
                    seq.push_back(8'($urandom_range(0, 254)));
                end
                default: seq.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        else
            seq.push_back(8'($urandom_range(0, 255)));

        foreach (seq[i])
            send_byte(seq[i], $urandom_range(0, 11) == 0);
        // swallowed tag bodies count as one item
        phase_items += (xml && style >= 10 && style <= 11) ? 1 : seq.size();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // markup off: '<' and '&' are plain text, telnet commands close text
        send_str("<&", 1'b0);
        send_byte(TN_IAC, 1'b0);
        send_byte(TN_WILL, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(TN_IAC, 1'b0);
        send_byte(TN_SB, 1'b0);
        send_byte(TN_IAC, 1'b0);
        send_byte(TN_SE, 1'b0);
        send_str("z", 1'b1);
        send_byte(TN_IAC, 1'b1);
        send_byte(8'h00, 1'b0);

        // markup on: tag, decoded entity, broken entities, chunk end mid entity
        write_mode(1'b1);
        send_str("h<>&lt;", 1'b0);
        send_str("&q", 1'b0);
        send_byte(CH_AMP, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_str("&l", 1'b1);
        send_str("t;", 1'b0);
        send_byte(CH_LT, 1'b0);
        directed_bytes = bytes_sent;

        // markup off while inside a tag
        write_mode(1'b0);
        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph > 0)
                write_mode(1'(ph % 2));
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                send_token(1'(ph % 2));
        end

        settle();
        repeat (20) @(posedge clk);
        $display("Sent %0d bytes (%0d directed) across %0d markup mode writes;",
                 bytes_sent, directed_bytes, mode_writes);
        $display("checked %0d output words with %0d mismatches.", words_checked, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
